>>> hdl/ec_pkg.sv
// ec_pkg: field widths, calendar constants and year tables for the
// epoch to calendar converter. No dependencies.
package ec_pkg;

    localparam int EPOCH_YEAR   = 1970;
    localparam int SECS_PER_MIN = 60;
    localparam int MIN_PER_HR   = 60;
    localparam int HR_PER_DAY   = 24;
    localparam int DAYS_LEAP    = 366;
    localparam int DAYS_NORM    = 365;
    localparam int FEB_LEAP     = 29;

    localparam int IN_W    = 32;
    localparam int IN_PAD  = 32;
    localparam int YEAR_W  = 12;
    localparam int MON_W   = 4;
    localparam int DAY_W   = 5;
    localparam int HR_W    = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int OUT_W   = YEAR_W + MON_W + DAY_W + HR_W + MIN_W + SEC_W;
    localparam int OUT_PAD = ((OUT_W + 7) / 8) * 8;

    localparam int MIN_CNT_W = 27;  // t / 60
    localparam int HR_CNT_W  = 21;  // t / 3600
    localparam int DAYS_W    = 16;  // t / 86400
    localparam int YIDX_W    = 8;
    localparam int NYR       = 1 << YIDX_W;
    localparam int START_W   = 17;
    localparam int DOY_W     = 9;
    localparam int NMON      = 12;
    localparam int MIDX_W    = 4;
    localparam int HMS_W     = HR_W + MIN_W + SEC_W;

    typedef logic [START_W-1:0] t_start_tab [NYR];
    typedef logic [NYR-1:0]     t_leap_tab;

    // first day of year of each month, common year
    localparam logic [DOY_W-1:0] MON_START [NMON] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    function automatic bit is_leap(input int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic t_start_tab build_year_start();
        t_start_tab tab;
        int         acc;
        acc = 0;
        for (int i = 0; i < NYR; i++) begin
            tab[i] = START_W'(acc);
            acc    = acc + (is_leap(EPOCH_YEAR + i) ? DAYS_LEAP : DAYS_NORM);
        end
        return tab;
    endfunction

    function automatic t_leap_tab build_year_leap();
        t_leap_tab tab;
        for (int i = 0; i < NYR; i++) begin
            tab[i] = is_leap(EPOCH_YEAR + i);
        end
        return tab;
    endfunction

    // day number of january 1st of each year, counted from the epoch
    localparam t_start_tab YEAR_START = build_year_start();
    localparam t_leap_tab  YEAR_LEAP  = build_year_leap();

endpackage

>>> hdl/epoch_to_calendar_unit.sv
// epoch_to_calendar_unit: top level, seconds since 1970 to calendar date/time.
// Depends on ec_pkg and ec_cdiv.
//
// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 UTC
// into Gregorian year, month, day, hour, minute and second with the full leap
// rule. The block is a fixed pipeline that takes one transfer per cycle while
// the output is not stalled. It holds three constant dividers of three stages
// each (by 60, 60 and 24), one load stage, an eight-stage binary search over a
// constant table of year start days, one stage for the day of year, one for
// the month and the output register. A stall at the output holds the whole
// pipeline; nothing is dropped or repeated.
module epoch_to_calendar_unit
    import ec_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [IN_PAD-1:0]  i_s_axis_tdata,   // [31:0] epoch_seconds
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    // [11:0] year, [15:12] month, [20:16] day, [25:21] hour,
    // [31:26] minute, [37:32] second, rest zero
    output logic [OUT_PAD-1:0] o_m_axis_tdata
);

    localparam int YS = YIDX_W;

    logic w_en;

    logic                 w_a_v;
    logic [IN_W-1:0]      w_a_q;
    logic [SEC_W-1:0]     w_a_r;
    logic                 w_b_v;
    logic [MIN_CNT_W-1:0] w_b_q;
    logic [MIN_W-1:0]     w_b_r;
    logic                 w_c_v;
    logic [HR_CNT_W-1:0]  w_c_q;
    logic [HR_W-1:0]      w_c_r;

    logic [SEC_W-1:0]       r_sec_d [3];
    logic [MIN_W+SEC_W-1:0] r_ms_d  [3];

    logic               r_sv   [YS+1];
    logic [YIDX_W-1:0]  r_lo   [YS+1];
    logic [DAYS_W-1:0]  r_days [YS+1];
    logic [HMS_W-1:0]   r_hms  [YS+1];

    logic               r_y_v;
    logic [YIDX_W-1:0]  r_y_lo;
    logic [DOY_W-1:0]   r_y_doy;
    logic               r_y_leap;
    logic [HMS_W-1:0]   r_y_hms;

    logic               r_m_v;
    logic [YIDX_W-1:0]  r_m_lo;
    logic [DOY_W-1:0]   r_m_doy;
    logic [MIDX_W-1:0]  r_m_mon;
    logic [DOY_W-1:0]   r_m_start;
    logic [HMS_W-1:0]   r_m_hms;

    logic               r_out_v;
    logic [YEAR_W-1:0]  r_year;
    logic [MON_W-1:0]   r_month;
    logic [DAY_W-1:0]   r_day;
    logic [HMS_W-1:0]   r_out_hms;

    logic [START_W-1:0] n_doy_full;
    logic [MIDX_W-1:0]  n_mon;
    logic [DOY_W-1:0]   n_mstart;

    assign w_en            = !r_out_v || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    ec_cdiv #(.XW(IN_W), .D(SECS_PER_MIN)) u_div_sec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_axis_tvalid),
        .i_x     (i_s_axis_tdata[IN_W-1:0]),
        .o_valid (w_a_v),
        .o_q     (w_a_q),
        .o_r     (w_a_r)
    );

    ec_cdiv #(.XW(MIN_CNT_W), .D(MIN_PER_HR)) u_div_min (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_a_v),
        .i_x     (w_a_q[MIN_CNT_W-1:0]),
        .o_valid (w_b_v),
        .o_q     (w_b_q),
        .o_r     (w_b_r)
    );

    ec_cdiv #(.XW(HR_CNT_W), .D(HR_PER_DAY)) u_div_hr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_b_v),
        .i_x     (w_b_q[HR_CNT_W-1:0]),
        .o_valid (w_c_v),
        .o_q     (w_c_q),
        .o_r     (w_c_r)
    );

    // remainders ride alongside the next divider
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sec_d[0] <= w_a_r;
            r_sec_d[1] <= r_sec_d[0];
            r_sec_d[2] <= r_sec_d[1];
            r_ms_d[0]  <= {w_b_r, r_sec_d[2]};
            r_ms_d[1]  <= r_ms_d[0];
            r_ms_d[2]  <= r_ms_d[1];
        end
    end

    // year search: one index bit per stage, msb first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (w_en) begin
            r_sv[0] <= w_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lo[0]   <= '0;
            r_days[0] <= w_c_q[DAYS_W-1:0];
            r_hms[0]  <= {w_c_r, r_ms_d[2]};
        end
    end

    for (genvar s = 1; s <= YS; s++) begin : g_search
        logic [YIDX_W-1:0] w_cand;
        assign w_cand = r_lo[s-1] | (YIDX_W'(1) << (YIDX_W - s));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[s] <= 1'b0;
            end else if (w_en) begin
                r_sv[s] <= r_sv[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_days[s] <= r_days[s-1];
                r_hms[s]  <= r_hms[s-1];
                if (START_W'(r_days[s-1]) >= YEAR_START[w_cand]) begin
                    r_lo[s] <= w_cand;
                end else begin
                    r_lo[s] <= r_lo[s-1];
                end
            end
        end
    end

    assign n_doy_full = START_W'(r_days[YS]) - YEAR_START[r_lo[YS]];

    always_comb begin
        logic [DOY_W-1:0] thr [NMON];
        for (int m = 0; m < NMON; m++) begin
            thr[m] = MON_START[m] + DOY_W'(r_y_leap && (m >= 2));
        end
        n_mon = '0;
        for (int m = 1; m < NMON; m++) begin
            if (r_y_doy >= thr[m]) begin
                n_mon = MIDX_W'(m);
            end
        end
        n_mstart = thr[n_mon];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y_v   <= 1'b0;
            r_m_v   <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_y_v   <= r_sv[YS];
            r_m_v   <= r_y_v;
            r_out_v <= r_m_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_y_lo    <= r_lo[YS];
            r_y_doy   <= n_doy_full[DOY_W-1:0];
            r_y_leap  <= YEAR_LEAP[r_lo[YS]];
            r_y_hms   <= r_hms[YS];

            r_m_lo    <= r_y_lo;
            r_m_doy   <= r_y_doy;
            r_m_mon   <= n_mon;
            r_m_start <= n_mstart;
            r_m_hms   <= r_y_hms;

            r_year    <= YEAR_W'(EPOCH_YEAR) + YEAR_W'(r_m_lo);
            r_month   <= r_m_mon + MON_W'(1);
            r_day     <= DAY_W'(r_m_doy - r_m_start + DOY_W'(1));
            r_out_hms <= r_m_hms;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = OUT_PAD'({r_out_hms[SEC_W-1:0],
                                       r_out_hms[MIN_W+SEC_W-1:SEC_W],
                                       r_out_hms[HMS_W-1:MIN_W+SEC_W],
                                       r_day, r_month, r_year});

    a_year_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_year >= YEAR_W'(EPOCH_YEAR)) && (r_year <= YEAR_W'(2106)))
        else $error("year out of range");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_month >= MON_W'(1)) && (r_month <= MON_W'(NMON)) &&
                    (r_day >= DAY_W'(1)))
        else $error("month or day out of range");

    a_feb_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && (r_month == MON_W'(2))) |-> (r_day <= DAY_W'(FEB_LEAP)))
        else $error("february day too large");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_out_hms[HMS_W-1:MIN_W+SEC_W] < HR_W'(HR_PER_DAY)) &&
                    (r_out_hms[MIN_W+SEC_W-1:SEC_W] < MIN_W'(MIN_PER_HR)) &&
                    (r_out_hms[SEC_W-1:0] < SEC_W'(SECS_PER_MIN)))
        else $error("time of day out of range");

endmodule

>>> hdl/ec_cdiv.sv
// ec_cdiv: three-stage pipelined division of an unsigned value by a
// constant, reciprocal multiply plus one correction step. No dependencies.
module ec_cdiv #(
    parameter int XW = 32,
    parameter int D  = 60,
    localparam int RW = $clog2(D)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [XW-1:0] i_x,
    output logic          o_valid,
    output logic [XW-1:0] o_q,
    output logic [RW-1:0] o_r
);

    localparam int PW = 2 * XW;
    localparam longint unsigned RECIP = (64'd1 << XW) / D;

    logic [2:0]    r_v;
    logic [XW-1:0] r_x1;
    logic [PW-1:0] r_prod;
    logic [XW-1:0] r_x2;
    logic [XW-1:0] r_q2;
    logic [XW-1:0] r_qd2;
    logic [XW-1:0] r_q;
    logic [RW-1:0] r_r;

    logic [XW-1:0] n_q2;
    logic [XW-1:0] n_rem;
    logic [XW-1:0] n_q;
    logic [XW-1:0] n_r;

    always_comb begin
        n_q2  = r_prod[PW-1:XW];
        n_rem = r_x2 - r_qd2;
        // estimate is at most one low
        if (n_rem >= XW'(D)) begin
            n_q = r_q2 + XW'(1);
            n_r = n_rem - XW'(D);
        end else begin
            n_q = r_q2;
            n_r = n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x1   <= i_x;
            r_prod <= PW'(i_x) * PW'(RECIP);
            r_x2   <= r_x1;
            r_q2   <= n_q2;
            r_qd2  <= XW'(n_q2 * XW'(D));
            r_q    <= n_q;
            r_r    <= n_r[RW-1:0];
        end
    end

    assign o_valid = r_v[2];
    assign o_q     = r_q;
    assign o_r     = r_r;

endmodule

>>> verif/epoch_to_calendar_unit_test.sv
`timescale 1ns / 100ps
// epoch_to_calendar_unit_test: self-checking testbench for epoch_to_calendar_unit.
// Scoreboard class predicts each date from the accepted epoch count; tasks drive
// the stream ports. Depends on ec_pkg and the converter RTL.
module epoch_to_calendar_unit_test;
    import ec_pkg::*;

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [MON_W-1:0]  month;
        logic [DAY_W-1:0]  day;
        logic [HR_W-1:0]   hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
    } t_date_time;

    typedef struct {
        logic [IN_W-1:0] epoch;
        t_date_time      date;
    } t_pending_date;

    class calendar_scoreboard;
        t_pending_date expected_dates[$];
        int            errors;
        int unsigned   month_days[NMON];

        function new();
            errors     = 0;
            month_days = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        endfunction

        function bit gregorian_leap(input int unsigned y);
            if (y % 400 == 0) return 1'b1;
            if (y % 100 == 0) return 1'b0;
            return (y % 4 == 0);
        endfunction

        function t_date_time seconds_to_date(input logic [IN_W-1:0] secs);
            t_date_time  r;
            int unsigned days;
            int unsigned yr;
            int unsigned mo;
            int unsigned ylen;
            int unsigned mlen;
            r.second = SEC_W'(secs % SECS_PER_MIN);
            r.minute = MIN_W'((secs / SECS_PER_MIN) % MIN_PER_HR);
            r.hour   = HR_W'((secs / (SECS_PER_MIN * MIN_PER_HR)) % HR_PER_DAY);
            days     = secs / (SECS_PER_MIN * MIN_PER_HR * HR_PER_DAY);
            yr       = EPOCH_YEAR;
            ylen     = gregorian_leap(yr) ? DAYS_LEAP : DAYS_NORM;
            while (days >= ylen) begin
                days = days - ylen;
                yr   = yr + 1;
                ylen = gregorian_leap(yr) ? DAYS_LEAP : DAYS_NORM;
            end
            mo = 0;
            while (mo < NMON) begin
                mlen = (mo == 1 && gregorian_leap(yr)) ? FEB_LEAP : month_days[mo];
                if (days < mlen) break;
                days = days - mlen;
                mo   = mo + 1;
            end
            r.year  = YEAR_W'(yr);
            r.month = MON_W'(mo + 1);
            r.day   = DAY_W'(days + 1);
            return r;
        endfunction

        function void note_epoch(input logic [IN_W-1:0] secs);
            t_pending_date p;
            p.epoch = secs;
            p.date  = seconds_to_date(secs);
            expected_dates.push_back(p);
        endfunction

        function int pending();
            return expected_dates.size();
        endfunction

        function void compare_field(input string name, input logic [IN_W-1:0] secs,
                                    input int unsigned want, input int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch for epoch %0d, expected %0d, actual %0d",
                         $time, name, secs, want, got);
            end
        endfunction

        function void check_date(input logic [OUT_PAD-1:0] data);
            t_pending_date p;
            if (expected_dates.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual 0x%0h", $time, data);
                return;
            end
            p = expected_dates.pop_front();
            compare_field("year",   p.epoch, p.date.year,   data[11:0]);
            compare_field("month",  p.epoch, p.date.month,  data[15:12]);
            compare_field("day",    p.epoch, p.date.day,    data[20:16]);
            compare_field("hour",   p.epoch, p.date.hour,   data[25:21]);
            compare_field("minute", p.epoch, p.date.minute, data[31:26]);
            compare_field("second", p.epoch, p.date.second, data[37:32]);
            compare_field("padding", p.epoch, 0, data[OUT_PAD-1:OUT_W]);
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_s_axis_tvalid = 1'b0;
    logic               o_s_axis_tready;
    logic [IN_PAD-1:0]  i_s_axis_tdata = '0;   // [31:0] epoch_seconds
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready = 1'b0;
    // [11:0] year, [15:12] month, [20:16] day, [25:21] hour,
    // [31:26] minute, [37:32] second, rest zero
    logic [OUT_PAD-1:0] o_m_axis_tdata;

    calendar_scoreboard board = new();
    bit                 idle_on = 1'b1;
    bit                 quiet = 1'b0;
    bit                 hold_output = 1'b0;

    epoch_to_calendar_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        if (quiet || !idle_on || $urandom_range(0, 2) != 0) return 0;
        return $urandom_range(1, 9);
    endfunction

    task automatic offer_epoch(input logic [IN_W-1:0] secs, input int gap);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= secs;
        do @(posedge i_clk); while (!o_s_axis_tready);
        board.note_epoch(secs);
    endtask

    task automatic drain_dates();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    // receiver side
    initial begin
        forever begin
            if (hold_output) begin
                hold_output = 1'b0;
                i_m_axis_tready <= 1'b0;
                repeat (120) @(posedge i_clk);
            end else if (quiet || !idle_on) begin
                i_m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            board.check_date(o_m_axis_tdata);
    end

    initial begin
        #2_000_000;
        $display("epoch_to_calendar_unit_test: FAIL");
        $finish;
    end

    initial begin
        logic [IN_W-1:0] directed [$];
        logic [IN_W-1:0] secs;
        int unsigned     first_day;
        int unsigned     yr;
        int unsigned     offsets [5];
        directed = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399,
                     32'd86400, 32'd68169600, 32'd94694399, 32'd94694400,
                     32'd951782400, 32'd951868800, 32'd978307199, 32'd2147483647,
                     32'd2147483648, 32'd4107456000, 32'd4107542399, 32'd4107542400,
                     32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
        offsets  = '{0, 58, 59, 60, 365};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i])
            offer_epoch(directed[i], pick_gap());

        for (int n = 0; n < 500; n++) begin
            if (n % 50 == 0)
                idle_on = (n % 100 == 0);
            if (n == 420)
                quiet = 1'b1;
            if (n == 150)
                hold_output = 1'b1;
            if (n == 300)
                drain_dates();
            case ($urandom_range(0, 3))
                0: secs = $urandom;
                1: secs = $urandom_range(0, 49710) * 86400 + $urandom_range(0, 4) - 2;
                2: begin
                    yr        = $urandom_range(EPOCH_YEAR, 2106);
                    first_day = 0;
                    for (int y = EPOCH_YEAR; y < yr; y++)
                        first_day += board.gregorian_leap(y) ? DAYS_LEAP : DAYS_NORM;
                    secs = (first_day + offsets[$urandom_range(0, 4)]) * 86400
                           + $urandom_range(0, 86399);
                end
                default: begin
                    if ($urandom_range(0, 1) != 0)
                        secs = 32'hFFFF_FFFF - $urandom_range(0, 200000);
                    else
                        secs = $urandom_range(0, 200000);
                end
            endcase
            offer_epoch(secs, pick_gap());
        end

        drain_dates();
        repeat (30) @(posedge i_clk);
        if (board.errors == 0)
            $display("epoch_to_calendar_unit_test: PASS");
        else
            $display("epoch_to_calendar_unit_test: FAIL");
        $finish;
    end

endmodule

>>> epoch_to_calendar_unit.f
hdl/ec_pkg.sv
hdl/ec_cdiv.sv
hdl/epoch_to_calendar_unit.sv
verif/epoch_to_calendar_unit_test.sv
